// ===== hw/rtl/pvmppt_pkg.sv =====
`default_nettype none

package pvmppt_pkg;

    // string count and the string fields that exist on the sample
    localparam int NUM_STRINGS   = 4;
    localparam int FIELD_STRINGS = 4;
    localparam int SCAN_STRINGS  = (NUM_STRINGS < FIELD_STRINGS) ? NUM_STRINGS : FIELD_STRINGS;

    // field widths
    localparam int TIME_W  = 32;
    localparam int POWER_W = 20;
    localparam int VOLT_W  = 16;
    localparam int STEP_W  = 16;
    localparam int IVL_W   = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRING_MAX_V   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POWER      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_TICKS = 3'd4;

    // lowest string voltage taken as a measurement (0.1 V)
    localparam logic [VOLT_W-1:0] MIN_VALID_V = 16'd10;

    // Q16 fractions of the rated string voltage
    localparam logic [15:0] Q16_078 = 16'd51118;
    localparam logic [15:0] Q16_050 = 16'd32768;
    localparam logic [15:0] Q16_095 = 16'd62259;

    typedef enum logic [1:0] {
        ALGO_OFF = 2'd0,
        ALGO_PO  = 2'd1,
        ALGO_IC  = 2'd2,
        ALGO_CV  = 2'd3
    } algo_t;

    typedef struct packed {
        algo_t               algorithm;
        logic [STEP_W-1:0]   step_size;
        logic [VOLT_W-1:0]   string_max_voltage;
        logic [POWER_W-1:0]  min_power;
        logic [IVL_W-1:0]    interval_ticks;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]                      time_now;
        logic                                   run_enabled;
        logic [POWER_W-1:0]                     sample_power;
        logic [FIELD_STRINGS-1:0][VOLT_W-1:0]   string_voltage;
    } sample_t;

    typedef struct packed {
        logic [VOLT_W-1:0]   vref_hold;
        logic [POWER_W-1:0]  observe_power_ref;
        logic [POWER_W-1:0]  conductance_prev_power;
        logic [VOLT_W-1:0]   conductance_prev_voltage;
        logic [TIME_W-1:0]   last_update_time;
        logic                has_updated;
    } trk_state_t;

    // round-to-nearest fraction k/65536 of vmax
    function automatic logic [VOLT_W-1:0] frac_of_vmax(input logic [VOLT_W-1:0] vmax,
                                                       input logic [15:0] k);
        logic [32:0] prod;
        prod = 33'(vmax) * 33'(k) + 33'd32768;
        return prod[31:16];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pvmppt_update.sv =====
`default_nettype none

module pvmppt_update
    import pvmppt_pkg::*;
(
    input  wire cfg_t         cfg,
    input  wire trk_state_t   cur,
    input  wire sample_t      smp,
    output trk_state_t        nxt,
    output logic [VOLT_W-1:0] vref,
    output logic              updated
);

    logic [TIME_W-1:0]   elapsed;
    logic                skip;
    logic [VOLT_W-1:0]   vmeas;
    logic                have_v;
    logic [VOLT_W-1:0]   f078;
    logic [VOLT_W-1:0]   lo;
    logic [VOLT_W-1:0]   hi;
    logic [VOLT_W-1:0]   cv_po;
    logic [VOLT_W-1:0]   cv_ic;
    logic [VOLT_W-1:0]   dv;
    logic [POWER_W-1:0]  dp;
    logic [35:0]         prod_dp_v;
    logic [35:0]         prod_p_dv;
    logic signed [17:0]  step_s;
    logic signed [17:0]  hold_s;
    logic signed [17:0]  vref_w;
    logic signed [17:0]  lo_s;
    logic signed [17:0]  hi_s;

    // skip test: run flag, power floor, update interval
    assign elapsed = smp.time_now - cur.last_update_time;
    assign skip = !smp.run_enabled || (smp.sample_power <= cfg.min_power) ||
                  (cur.has_updated && (elapsed < TIME_W'(cfg.interval_ticks)));

    // first string at or above the valid floor
    always_comb begin
        vmeas  = '0;
        have_v = 1'b0;
        for (int i = SCAN_STRINGS - 1; i >= 0; i--) begin
            if (smp.string_voltage[i] >= MIN_VALID_V) begin
                vmeas  = smp.string_voltage[i];
                have_v = 1'b1;
            end
        end
    end

    // fractions of the rated voltage
    assign f078 = frac_of_vmax(cfg.string_max_voltage, Q16_078);
    assign lo   = frac_of_vmax(cfg.string_max_voltage, Q16_050);
    assign hi   = frac_of_vmax(cfg.string_max_voltage, Q16_095);

    // incremental conductance terms, compared without division
    assign cv_po = have_v ? vmeas : cur.vref_hold;
    assign cv_ic = have_v ? vmeas : cur.conductance_prev_voltage;
    assign dv = (cv_ic >= cur.conductance_prev_voltage) ? cv_ic - cur.conductance_prev_voltage
                                                         : cur.conductance_prev_voltage - cv_ic;
    assign dp = (smp.sample_power >= cur.conductance_prev_power)
              ? smp.sample_power - cur.conductance_prev_power
              : cur.conductance_prev_power - smp.sample_power;
    assign prod_dp_v = 36'(dp) * 36'(cv_ic);
    assign prod_p_dv = 36'(smp.sample_power) * 36'(dv);

    assign step_s = signed'(18'(cfg.step_size));
    assign hold_s = signed'(18'(cur.vref_hold));
    assign lo_s   = signed'(18'(lo));
    assign hi_s   = signed'(18'(hi));

    // mode update, clamp and state
    always_comb begin
        nxt    = cur;
        vref_w = hold_s;
        case (cfg.algorithm)
            ALGO_PO: begin
                if (cur.observe_power_ref == '0) begin
                    vref_w = (cv_po != '0) ? signed'(18'(cv_po)) : signed'(18'(f078));
                end else if ((smp.sample_power > cur.observe_power_ref) ==
                             (cv_po > cur.vref_hold)) begin
                    vref_w = hold_s + step_s;
                end else begin
                    vref_w = hold_s - step_s;
                end
                nxt.observe_power_ref = smp.sample_power;
            end
            ALGO_IC: begin
                if ((dv != '0) && (cv_ic != '0)) begin
                    vref_w = (prod_dp_v > prod_p_dv) ? hold_s + step_s : hold_s - step_s;
                end
                nxt.conductance_prev_power   = smp.sample_power;
                nxt.conductance_prev_voltage = cv_ic;
            end
            ALGO_CV: begin
                vref_w = signed'(18'(f078));
            end
            default: begin
                vref_w = '0;
            end
        endcase
        if (vref_w < lo_s) begin
            vref_w = lo_s;
        end
        if (vref_w > hi_s) begin
            vref_w = hi_s;
        end
        nxt.vref_hold        = vref_w[VOLT_W-1:0];
        nxt.last_update_time = smp.time_now;
        nxt.has_updated      = 1'b1;
        updated = !skip;
        vref    = cur.vref_hold;
        if (skip) begin
            nxt = cur;
        end else begin
            vref = vref_w[VOLT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pv_mppt_voltage_tracker.sv =====
`default_nettype none

// Maximum power point voltage reference tracker. One sample beat is taken per
// clock, back to back, while the result stream is not stalled; its result beat
// passes the input register, then the result register, and the tracking state
// is updated in the same cycle the result is registered, so the next sample
// already sees it. A stalled result holds the sample behind it in the input
// register. The configuration channel is always ready and writes to unknown
// indexes are ignored; write registers only while no sample is in flight. No
// clearing pass after reset.
module pv_mppt_voltage_tracker
    import pvmppt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // sample stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] time_now, [32] run_enabled, [52:33] sample_power,
    // [68:53] string0_voltage, [84:69] string1_voltage,
    // [100:85] string2_voltage, [116:101] string3_voltage, [119:117] zero
    input  wire logic [119:0]          s_tdata,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [15:0] voltage_reference
    output logic [15:0]                m_tdata,
    // [0] updated
    output logic [0:0]                 m_tuser,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg_reg;
    sample_t           in_smp_reg;
    logic              in_valid_reg;
    trk_state_t        state_reg;
    trk_state_t        state_next;
    logic              out_valid_reg;
    logic [VOLT_W-1:0] out_vref_reg;
    logic              out_updated_reg;
    logic [VOLT_W-1:0] vref_next;
    logic              updated_next;
    logic              advance;
    logic              fire;
    sample_t           s_smp;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.algorithm          <= ALGO_PO;
            cfg_reg.step_size          <= 16'd50;
            cfg_reg.string_max_voltage <= 16'd60000;
            cfg_reg.min_power          <= 20'd1;
            cfg_reg.interval_ticks     <= 16'd100;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ALGORITHM:      cfg_reg.algorithm          <= algo_t'(cfg_data[1:0]);
                CFG_STEP_SIZE:      cfg_reg.step_size          <= cfg_data[STEP_W-1:0];
                CFG_STRING_MAX_V:   cfg_reg.string_max_voltage <= cfg_data[VOLT_W-1:0];
                CFG_MIN_POWER:      cfg_reg.min_power          <= cfg_data[POWER_W-1:0];
                CFG_INTERVAL_TICKS: cfg_reg.interval_ticks     <= cfg_data[IVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // unpack the sample beat
    always_comb begin
        s_smp.time_now          = s_tdata[31:0];
        s_smp.run_enabled       = s_tdata[32];
        s_smp.sample_power      = s_tdata[52:33];
        s_smp.string_voltage[0] = s_tdata[68:53];
        s_smp.string_voltage[1] = s_tdata[84:69];
        s_smp.string_voltage[2] = s_tdata[100:85];
        s_smp.string_voltage[3] = s_tdata[116:101];
    end

    // handshake between the two register stages
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_smp_reg <= s_smp;
        end
    end

    pvmppt_update u_update (
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .smp     (in_smp_reg),
        .nxt     (state_next),
        .vref    (vref_next),
        .updated (updated_next)
    );

    // tracking state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                state_reg <= state_next;
            end
        end
        if (fire) begin
            out_vref_reg    <= vref_next;
            out_updated_reg <= updated_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_vref_reg;
    assign m_tuser[0] = out_updated_reg;

`ifndef SYNTHESIS
    logic [VOLT_W-1:0] chk_lo;
    logic [VOLT_W-1:0] chk_hi;
    assign chk_lo = frac_of_vmax(cfg_reg.string_max_voltage, Q16_050);
    assign chk_hi = frac_of_vmax(cfg_reg.string_max_voltage, Q16_095);

    // a waiting result always matches the held reference
    a_out_matches_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == state_reg.vref_hold))
        else $error("result beat differs from held reference");

    // an updated reference lies within the clamp window
    a_updated_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> ((m_tdata >= chk_lo) && (m_tdata <= chk_hi)))
        else $error("updated reference outside clamp window");

    // an update beat implies the interval timer is armed
    a_update_arms_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> state_reg.has_updated)
        else $error("update without has_updated set");

    // a blocked sample stays in the input register unchanged
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_smp_reg)))
        else $error("blocked sample lost or changed");
`endif

endmodule

`default_nettype wire
